// ===== rtl/bps_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bps_pkg
// Shared widths, defaults and operation codes of the budget path search.
// ---------------------------------------------------------------------------
package bps_pkg;

   localparam int VW                = 7;
   localparam int MW                = 32;
   localparam int DEF_MAX_VERTICES  = 64;
   localparam int DEF_MAX_EDGES     = 256;
   localparam logic [VW-1:0] VCOUNT_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_GAIN   = 2'd1,
      OP_EDGE   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

endpackage

// ===== rtl/bps_ifs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bps channel interfaces
// Request, response and register write channels with valid/ready transfer.
// ---------------------------------------------------------------------------
interface bps_req_if;
   logic                                valid;
   logic                                ready;
   bps_pkg::op_type                     op;
   logic        [bps_pkg::VW-1:0]       gain_vertex;
   logic signed [bps_pkg::MW-1:0]       gain_value;
   logic        [bps_pkg::VW-1:0]       edge_from;
   logic        [bps_pkg::VW-1:0]       edge_to;
   logic signed [bps_pkg::MW-1:0]       edge_cost;
   logic        [bps_pkg::VW-1:0]       start_vertex;
   logic        [bps_pkg::VW-1:0]       end_vertex;
   logic signed [bps_pkg::MW-1:0]       budget;
   modport source (output valid, op, gain_vertex, gain_value, edge_from, edge_to,
                   edge_cost, start_vertex, end_vertex, budget, input ready);
   modport sink   (input valid, op, gain_vertex, gain_value, edge_from, edge_to,
                   edge_cost, start_vertex, end_vertex, budget, output ready);
endinterface

interface bps_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [bps_pkg::VW-1:0]   path_vertex;
   logic                     found;
   logic                     last;
   modport source (output valid, path_vertex, found, last, input ready);
   modport sink   (input valid, path_vertex, found, last, output ready);
endinterface

interface bps_csr_if;
   logic                     valid;
   logic                     ready;
   logic [bps_pkg::VW-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/bps_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bps_ram
// Single write port, single read port memory with registered read data.
// ---------------------------------------------------------------------------
module bps_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/budget_path_search.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// budget_path_search
// Budget-limited depth-first path search over a loaded undirected graph.
// ---------------------------------------------------------------------------
// Usage:
//  req  : one item per transfer. Clear, set gain and add edge build the graph;
//         search walks it from start_vertex to end_vertex.
//  rsp  : search results, one transfer per path vertex (start first, last=1
//         on the end vertex), or a single transfer with found=0.
//  csr  : writes vertex_count; always ready, write only while idle.
// Operation: clear and set gain are done in the idle state. Add edge scans
//  the E stored entries for a duplicate over the single edge memory port,
//  then writes up to two entries. A search scans the edge entries of each
//  vertex entered, returns to the parent of each vertex left, and emits each
//  path vertex; the one-port edge memory read is the limiting step. req_ready
//  is low meanwhile.
// Reset: synchronous, clears the graph, gains and vertex_count to 64.
// A stalled rsp holds the block in its emit step until the transfer is taken.
// ---------------------------------------------------------------------------
module budget_path_search #(
   parameter int MAX_VERTICES = bps_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = bps_pkg::DEF_MAX_EDGES
) (
   input  logic       clock,
   input  logic       reset,
   bps_req_if.sink    req,
   bps_rsp_if.source  rsp,
   bps_csr_if.sink    csr
);
   import bps_pkg::*;

   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int SDW = $clog2(MAX_VERTICES + 1);
   localparam int SAW = $clog2(MAX_VERTICES);
   localparam int EW  = 2 * VW + MW;
   localparam int SW  = VW + ECW + MW;
   localparam logic [VW-1:0]  MAXV  = VW'(MAX_VERTICES);
   localparam logic [SDW-1:0] MAXD  = SDW'(MAX_VERTICES);
   localparam logic [ECW:0]   MAXE  = (ECW + 1)'(MAX_EDGES);

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_ADD_RD  = 14'b00000000000010,
      S_ADD_CMP = 14'b00000000000100,
      S_ADD_WR1 = 14'b00000000001000,
      S_ADD_WR2 = 14'b00000000010000,
      S_CHECK   = 14'b00000000100000,
      S_SCAN    = 14'b00000001000000,
      S_EVAL    = 14'b00000010000000,
      S_GAIN    = 14'b00000100000000,
      S_POP     = 14'b00001000000000,
      S_RESTORE = 14'b00010000000000,
      S_EMIT_RD = 14'b00100000000000,
      S_EMIT_WR = 14'b01000000000000,
      S_MISS    = 14'b10000000000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [VW-1:0]                 vcount_ff, vcount_in;
   logic [VW-1:0]                 a_ff, a_in, b_ff, b_in, child_ff, child_in;
   logic [MW-1:0]                 val_ff, val_in, diff_ff, diff_in;
   logic [ECW-1:0]                total_ff, total_in, k_ff, k_in;
   logic [SDW-1:0]                depth_ff, depth_in, emit_ff, emit_in;
   logic [VW-1:0]                 top_vtx_ff, top_vtx_in;
   logic [ECW-1:0]                top_scan_ff, top_scan_in;
   logic [MW-1:0]                 top_money_ff, top_money_in;
   logic [MAX_VERTICES-1:0][1:0]  visit_ff, visit_in;
   logic [MAX_VERTICES-1:0]       gvalid_ff, gvalid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                 rsp_vtx_ff, rsp_vtx_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic           edge_we, gain_we, stk_we;
   logic [EAW-1:0] edge_waddr, edge_raddr;
   logic [EW-1:0]  edge_wdata, edge_q;
   logic [SAW-1:0] gain_waddr, gain_raddr, stk_waddr, stk_raddr;
   logic [MW-1:0]  gain_wdata, gain_q;
   logic [SW-1:0]  stk_wdata, stk_q;

   logic [VW-1:0]  live, eq_from, eq_to;
   logic [MW-1:0]  eq_cost;
   logic           slot_free, req_take;
   logic [ECW:0]   need_total;

   function automatic logic vtx_ok(input logic [VW-1:0] v, input logic [VW-1:0] n);
      vtx_ok = (v != '0) && (v <= n);
   endfunction

   function automatic logic [SAW-1:0] vidx(input logic [VW-1:0] v);
      logic [VW-1:0] t;
      t    = v - VW'(1);
      vidx = t[SAW-1:0];
   endfunction

   bps_ram #(.DEPTH(MAX_EDGES), .WIDTH(EW)) u_edge (
      .clock(clock), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
      .raddr(edge_raddr), .rdata(edge_q));

   bps_ram #(.DEPTH(MAX_VERTICES), .WIDTH(MW)) u_gain (
      .clock(clock), .we(gain_we), .waddr(gain_waddr), .wdata(gain_wdata),
      .raddr(gain_raddr), .rdata(gain_q));

   bps_ram #(.DEPTH(MAX_VERTICES), .WIDTH(SW)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_q));

   assign live      = (vcount_ff < MAXV) ? vcount_ff : MAXV;
   assign eq_from   = edge_q[EW-1 -: VW];
   assign eq_to     = edge_q[MW +: VW];
   assign eq_cost   = edge_q[MW-1:0];
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req_take  = req.valid && req.ready;
   assign need_total = {1'b0, total_ff} + ((a_ff == b_ff) ? (ECW + 1)'(1) : (ECW + 1)'(2));

   assign req.ready       = (state_ff == S_IDLE);
   assign csr.ready       = 1'b1;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.path_vertex = rsp_vtx_ff;
   assign rsp.found       = rsp_found_ff;
   assign rsp.last        = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      val_in       = val_ff;
      child_in     = child_ff;
      diff_in      = diff_ff;
      total_in     = total_ff;
      k_in         = k_ff;
      depth_in     = depth_ff;
      emit_in      = emit_ff;
      top_vtx_in   = top_vtx_ff;
      top_scan_in  = top_scan_ff;
      top_money_in = top_money_ff;
      visit_in     = visit_ff;
      gvalid_in    = gvalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_vtx_in   = rsp_vtx_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      edge_we      = 1'b0;
      edge_waddr   = total_ff[EAW-1:0];
      edge_wdata   = {a_ff, b_ff, val_ff};
      edge_raddr   = k_ff[EAW-1:0];
      gain_we      = 1'b0;
      gain_waddr   = vidx(req.gain_vertex);
      gain_wdata   = req.gain_value;
      gain_raddr   = vidx(eq_to);
      stk_we       = 1'b0;
      stk_waddr    = '0;
      stk_wdata    = {req.start_vertex, total_ff, req.budget};
      stk_raddr    = '0;

      if (csr.valid) begin
         vcount_in = csr.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               unique case (req.op)
                  OP_CLEAR: begin
                     total_in  = '0;
                     gvalid_in = '0;
                  end
                  OP_GAIN: begin
                     if (vtx_ok(req.gain_vertex, live)) begin
                        gain_we = 1'b1;
                        gvalid_in[vidx(req.gain_vertex)] = 1'b1;
                     end
                  end
                  OP_EDGE: begin
                     a_in   = req.edge_from;
                     b_in   = req.edge_to;
                     val_in = req.edge_cost;
                     k_in   = '0;
                     if (vtx_ok(req.edge_from, live) && vtx_ok(req.edge_to, live)) begin
                        state_in = S_ADD_RD;
                     end
                  end
                  OP_SEARCH: begin
                     b_in     = req.end_vertex;
                     visit_in = '0;
                     depth_in = '0;
                     if (vtx_ok(req.start_vertex, live) && vtx_ok(req.end_vertex, live)) begin
                        stk_we       = 1'b1;
                        top_vtx_in   = req.start_vertex;
                        top_scan_in  = total_ff;
                        top_money_in = req.budget;
                        visit_in[vidx(req.start_vertex)] = 2'd1;
                        depth_in     = SDW'(1);
                        state_in     = S_CHECK;
                     end else begin
                        state_in = S_MISS;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ADD_RD: begin
            state_in = (k_ff == total_ff) ? S_ADD_WR1 : S_ADD_CMP;
         end
         S_ADD_CMP: begin
            if (eq_from == a_ff && eq_to == b_ff) begin
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + ECW'(1);
               state_in = S_ADD_RD;
            end
         end
         S_ADD_WR1: begin
            if (need_total > MAXE) begin
               state_in = S_IDLE;
            end else begin
               edge_we  = 1'b1;
               total_in = total_ff + ECW'(1);
               state_in = (a_ff == b_ff) ? S_IDLE : S_ADD_WR2;
            end
         end
         S_ADD_WR2: begin
            edge_we    = 1'b1;
            edge_wdata = {b_ff, a_ff, val_ff};
            total_in   = total_ff + ECW'(1);
            state_in   = S_IDLE;
         end
         S_CHECK: begin
            if (top_vtx_ff == b_ff) begin
               emit_in  = '0;
               state_in = S_EMIT_RD;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (top_scan_ff == '0) begin
               visit_in[vidx(top_vtx_ff)] = 2'd2;
               depth_in = depth_ff - SDW'(1);
               state_in = (depth_ff == SDW'(1)) ? S_MISS : S_POP;
            end else begin
               top_scan_in = top_scan_ff - ECW'(1);
               edge_raddr  = top_scan_in[EAW-1:0];
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (eq_from == top_vtx_ff && vtx_ok(eq_to, live)
                && visit_ff[vidx(eq_to)] == 2'd0
                && $signed(top_money_ff) >= $signed(eq_cost) && depth_ff < MAXD) begin
               diff_in   = top_money_ff - eq_cost;
               child_in  = eq_to;
               stk_we    = 1'b1;
               stk_waddr = vidx(VW'(depth_ff));
               stk_wdata = {top_vtx_ff, top_scan_ff, top_money_ff};
               state_in  = S_GAIN;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_GAIN: begin
            top_vtx_in   = child_ff;
            top_scan_in  = total_ff;
            top_money_in = diff_ff + (gvalid_ff[vidx(child_ff)] ? gain_q : '0);
            stk_we       = 1'b1;
            stk_waddr    = depth_ff[SAW-1:0];
            stk_wdata    = {child_ff, total_ff, top_money_in};
            visit_in[vidx(child_ff)] = 2'd1;
            depth_in     = depth_ff + SDW'(1);
            state_in     = S_CHECK;
         end
         S_POP: begin
            stk_raddr = vidx(VW'(depth_ff));
            state_in  = S_RESTORE;
         end
         S_RESTORE: begin
            top_vtx_in   = stk_q[SW-1 -: VW];
            top_scan_in  = stk_q[MW +: ECW];
            top_money_in = stk_q[MW-1:0];
            state_in     = S_CHECK;
         end
         S_EMIT_RD: begin
            stk_raddr = emit_ff[SAW-1:0];
            state_in  = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            stk_raddr = emit_ff[SAW-1:0];
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_vtx_in   = stk_q[SW-1 -: VW];
               rsp_found_in = 1'b1;
               rsp_last_in  = (emit_ff == depth_ff - SDW'(1));
               if (rsp_last_in) begin
                  depth_in = '0;
                  state_in = S_IDLE;
               end else begin
                  emit_in  = emit_ff + SDW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_MISS: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_vtx_in   = '0;
               rsp_found_in = 1'b0;
               rsp_last_in  = 1'b1;
               depth_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vcount_ff    <= VCOUNT_RESET;
         total_ff     <= '0;
         depth_ff     <= '0;
         visit_ff     <= '0;
         gvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         total_ff     <= total_in;
         depth_ff     <= depth_in;
         visit_ff     <= visit_in;
         gvalid_ff    <= gvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff         <= a_in;
      b_ff         <= b_in;
      val_ff       <= val_in;
      child_ff     <= child_in;
      diff_ff      <= diff_in;
      k_ff         <= k_in;
      emit_ff      <= emit_in;
      top_vtx_ff   <= top_vtx_in;
      top_scan_ff  <= top_scan_in;
      top_money_ff <= top_money_in;
      rsp_vtx_ff   <= rsp_vtx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= MAXD) else $error("walk depth above vertex limit");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> depth_ff == '0) else $error("walk left open at idle");

   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, total_ff} <= MAXE) else $error("edge count above store size");

   a_push_unvisited: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GAIN |-> visit_ff[vidx(child_ff)] == 2'd0)
      else $error("entered a visited vertex");
`endif

endmodule
